[sv/mhcps_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, beat types and helper function for the comet pixel shader.
// No dependencies; every other file refers to it by scoped names.

package mhcps_pkg;

   // Default sizes of the strip and the comet
   localparam int STRIP_PIXELS = 300;
   localparam int HEADS        = 3;
   localparam int TAIL_SPAN    = 51;
   localparam int DIM_STEP     = 8;

   // Fixed field widths
   localparam int PIX_W   = 9;
   localparam int COLOR_W = 24;
   localparam int CH_W    = 8;

   // Reciprocal dimming: floor(c / div) == (c * ceil(2^16 / div)) >> 16 while c * div < 2^16
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_ONE   = 1 << RECIP_SHIFT;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   // Modulo reduction is split over two stages at this bit position
   localparam int MOD_SPLIT = 5;

   // Where the final color of a pixel comes from
   typedef enum logic [1:0] {
      SRC_BLANK,   // pixel outside the strip
      SRC_DIM,     // inside an eye, dimmed color
      SRC_FULL,    // at a head, full color
      SRC_KEEP     // unchanged, stored color
   } src_type;

   // Request beat as it travels down the pipe
   typedef struct packed {
      logic [PIX_W-1:0]   pix;
      logic [PIX_W-1:0]   head;
      logic [COLOR_W-1:0] color;
      logic               in_range;
   } item_type;

   // Conditional subtraction of span << k for k = hi down to lo
   function automatic logic [PIX_W-1:0] mod_reduce(input logic [PIX_W-1:0] value,
                                                   input int span, input int hi,
                                                   input int lo);
      logic [PIX_W-1:0] r;
      r = value;
      for (int k = hi; k >= lo; k--) begin
         if (int'(r) >= (span << k)) begin
            r = r - PIX_W'(span << k);
         end
      end
      return r;
   endfunction

endpackage

[sv/multi_head_comet_pixel_shader_core.sv]
`timescale 1ns / 1ps
// Top level of the comet pixel shader: pipeline wiring, frame store, final
// color select and output register. Uses mhcps_pkg, mhcps_dist, mhcps_eye, mhcps_dim.

// One pixel beat is accepted per clock unless a stall reaches the input or the
// store is being cleared; it passes three distance stages, two eye stages, the
// multiply and store read stages and the output register. Stalls back up stage
// by stage, so bubbles are squeezed out before the input stops. After reset the
// store is cleared one pixel per cycle; req_ready stays low until all StripPixels
// entries (300 by default) are zero. Back-to-back beats on the same pixel see
// each other's stored color through a one-entry bypass around the store. Pixels
// at or past StripPixels return color zero and leave the store untouched.

module multi_head_comet_pixel_shader_core #(
   parameter int StripPixels = mhcps_pkg::STRIP_PIXELS,
   parameter int Heads       = mhcps_pkg::HEADS,
   parameter int TailSpan    = mhcps_pkg::TAIL_SPAN,
   parameter int DimStep     = mhcps_pkg::DIM_STEP
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [mhcps_pkg::PIX_W-1:0]       req_pixel_index,
   input  logic [mhcps_pkg::PIX_W-1:0]       req_head_position,
   input  logic [mhcps_pkg::COLOR_W-1:0]     req_drop_color,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mhcps_pkg::PIX_W-1:0]       rsp_out_index,
   output logic [mhcps_pkg::COLOR_W-1:0]     rsp_out_color
);

   localparam int SpanRaw = StripPixels / Heads;
   localparam int Span    = (SpanRaw == 0) ? 1 : SpanRaw;
   localparam int DistW   = (Span > 1) ? $clog2(Span) : 1;
   localparam int AddrW   = $clog2(StripPixels);

   // Inter-module beats
   mhcps_pkg::item_type               req_item;
   logic                              dist_in_ready, dist_valid, eye_in_ready;
   mhcps_pkg::item_type               dist_item, eye_item, dim_item;
   logic [DistW-1:0]                  dist_d, dist_back;
   logic                              eye_valid, dim_in_ready, dim_valid;
   mhcps_pkg::src_type                eye_src, dim_src;
   logic [mhcps_pkg::RECIP_W-1:0]     eye_recip;
   logic [mhcps_pkg::COLOR_W-1:0]     dim_dimmed;

   // Stage 7 and output register
   logic                              s7_valid_ff, s7_valid_in, s7_adv, out_adv;
   mhcps_pkg::item_type               s7_item_ff;
   mhcps_pkg::src_type                s7_src_ff;
   logic [mhcps_pkg::COLOR_W-1:0]     s7_dimmed_ff;
   logic [mhcps_pkg::COLOR_W-1:0]     s7_result;
   logic [mhcps_pkg::COLOR_W-1:0]     s7_stored;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mhcps_pkg::PIX_W-1:0]       rsp_index_ff;
   logic [mhcps_pkg::COLOR_W-1:0]     rsp_color_ff;

   // Frame store and its clearing pass
   logic [mhcps_pkg::COLOR_W-1:0]     store_mem [StripPixels];
   logic [mhcps_pkg::COLOR_W-1:0]     rd_data_ff, byp_data_ff, wr_data;
   logic                              byp_hit_ff, byp_hit_in;
   logic [AddrW-1:0]                  rd_addr, wr_addr, s7_addr;
   logic                              wr_en, pipe_wr_en;
   logic                              clr_busy_ff, clr_busy_in;
   logic [AddrW-1:0]                  clr_cnt_ff, clr_cnt_in;

   // Input beat, gated during the clearing pass
   assign req_item.pix      = req_pixel_index;
   assign req_item.head     = req_head_position;
   assign req_item.color    = req_drop_color;
   assign req_item.in_range = (int'(req_pixel_index) < StripPixels);
   assign req_ready         = dist_in_ready & ~clr_busy_ff;

   mhcps_dist #(
      .Span  (Span),
      .DistW (DistW)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid & ~clr_busy_ff),
      .in_ready  (dist_in_ready),
      .in_item   (req_item),
      .out_valid (dist_valid),
      .out_ready (eye_in_ready),
      .out_item  (dist_item),
      .out_dist  (dist_d),
      .out_back  (dist_back)
   );

   mhcps_eye #(
      .Span     (Span),
      .DistW    (DistW),
      .TailSpan (TailSpan),
      .DimStep  (DimStep)
   ) u_eye (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dist_valid),
      .in_ready  (eye_in_ready),
      .in_item   (dist_item),
      .in_dist   (dist_d),
      .in_back   (dist_back),
      .out_valid (eye_valid),
      .out_ready (dim_in_ready),
      .out_item  (eye_item),
      .out_src   (eye_src),
      .out_recip (eye_recip)
   );

   mhcps_dim u_dim (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (eye_valid),
      .in_ready   (dim_in_ready),
      .in_item    (eye_item),
      .in_src     (eye_src),
      .in_recip   (eye_recip),
      .out_valid  (dim_valid),
      .out_ready  (s7_adv),
      .out_item   (dim_item),
      .out_src    (dim_src),
      .out_dimmed (dim_dimmed)
   );

   // Stage 7 handshake
   assign out_adv     = ~rsp_valid_ff | rsp_ready;
   assign s7_adv      = ~s7_valid_ff | out_adv;
   assign s7_valid_in = s7_adv ? dim_valid : s7_valid_ff;
   assign rsp_valid_in = out_adv ? s7_valid_ff : rsp_valid_ff;

   // Store addresses
   assign rd_addr = AddrW'(dim_item.pix);
   assign s7_addr = AddrW'(s7_item_ff.pix);

   // Stored color, with the beat written at the same edge as our read forwarded
   assign s7_stored = byp_hit_ff ? byp_data_ff : rd_data_ff;

   always_comb begin
      case (s7_src_ff)
         mhcps_pkg::SRC_BLANK: s7_result = '0;
         mhcps_pkg::SRC_DIM:   s7_result = s7_dimmed_ff;
         mhcps_pkg::SRC_FULL:  s7_result = s7_item_ff.color;
         mhcps_pkg::SRC_KEEP:  s7_result = s7_stored;
         default:              s7_result = '0;
      endcase
   end

   // Write port: clearing pass or write-back as a beat leaves stage 7
   assign pipe_wr_en = s7_valid_ff & out_adv & s7_item_ff.in_range;
   assign wr_en      = clr_busy_ff | pipe_wr_en;
   assign wr_addr    = clr_busy_ff ? clr_cnt_ff : s7_addr;
   assign wr_data    = clr_busy_ff ? '0 : s7_result;
   assign byp_hit_in = pipe_wr_en & (s7_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (s7_adv) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // Clearing pass sequencer
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == AddrW'(StripPixels - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         s7_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         byp_hit_ff   <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_cnt_ff   <= clr_cnt_in;
         s7_valid_ff  <= s7_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s7_adv) begin
            byp_hit_ff <= byp_hit_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s7_adv) begin
         s7_item_ff   <= dim_item;
         s7_src_ff    <= dim_src;
         s7_dimmed_ff <= dim_dimmed;
         byp_data_ff  <= s7_result;
      end
      if (out_adv) begin
         rsp_index_ff <= s7_item_ff.pix;
         rsp_color_ff <= s7_result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_color = rsp_color_ff;

   // No beat enters while the store is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_ready)
      else $error("beat accepted during frame store clear");

   // Pipeline write-back never collides with the clearing pass
   a_no_pipe_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !pipe_wr_en)
      else $error("pipeline write during frame store clear");

   // Pixels past the strip always come back black
   a_blank_out_of_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (int'(rsp_out_index) >= StripPixels)) |-> (rsp_out_color == '0))
      else $error("out-of-range pixel returned a color");

   // Response payload only changes when a new beat is loaded
   a_out_loaded_from_s7: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_color)))
      else $error("stalled response lost or changed");

endmodule

[sv/mhcps_dist.sv]
`timescale 1ns / 1ps
// Three pipeline stages: pixel and head reduced modulo the head spacing,
// then the forward and backward distance to the nearest head. Uses mhcps_pkg.

module mhcps_dist #(
   parameter int Span  = 100,
   parameter int DistW = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mhcps_pkg::item_type   in_item,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mhcps_pkg::item_type   out_item,
   output logic [DistW-1:0]      out_dist,
   output logic [DistW-1:0]      out_back
);

   localparam int DistXW = DistW + 1;

   logic                          s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic                          s1_valid_in, s2_valid_in, s3_valid_in;
   logic                          s1_adv, s2_adv, s3_adv;
   mhcps_pkg::item_type           s1_item_ff, s2_item_ff, s3_item_ff;
   logic [mhcps_pkg::PIX_W-1:0]   s1_pm_ff, s1_hm_ff, s2_pm_ff, s2_hm_ff;
   logic [mhcps_pkg::PIX_W-1:0]   s1_pm_in, s1_hm_in, s2_pm_in, s2_hm_in;
   logic [DistW-1:0]              s3_dist_ff, s3_back_ff, s3_dist_in, s3_back_in;
   logic [DistXW-1:0]             pm_ext, hm_ext;

   // Stall chain: a stage takes a beat when empty or when it drains
   assign s3_adv   = ~s3_valid_ff | out_ready;
   assign s2_adv   = ~s2_valid_ff | s3_adv;
   assign s1_adv   = ~s1_valid_ff | s2_adv;
   assign in_ready = s1_adv;

   assign s1_valid_in = s1_adv ? in_valid    : s1_valid_ff;
   assign s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_adv ? s2_valid_ff : s3_valid_ff;

   // Upper reduction steps
   assign s1_pm_in = mhcps_pkg::mod_reduce(in_item.pix, Span, mhcps_pkg::PIX_W - 1,
                                           mhcps_pkg::MOD_SPLIT);
   assign s1_hm_in = mhcps_pkg::mod_reduce(in_item.head, Span, mhcps_pkg::PIX_W - 1,
                                           mhcps_pkg::MOD_SPLIT);

   // Lower reduction steps
   assign s2_pm_in = mhcps_pkg::mod_reduce(s1_pm_ff, Span, mhcps_pkg::MOD_SPLIT - 1, 0);
   assign s2_hm_in = mhcps_pkg::mod_reduce(s1_hm_ff, Span, mhcps_pkg::MOD_SPLIT - 1, 0);

   // d = (pm - hm) mod Span, back = (Span - d) mod Span
   assign pm_ext = DistXW'(s2_pm_ff);
   assign hm_ext = DistXW'(s2_hm_ff);

   always_comb begin
      if (pm_ext >= hm_ext) begin
         s3_dist_in = DistW'(pm_ext - hm_ext);
      end else begin
         s3_dist_in = DistW'(pm_ext + DistXW'(Span) - hm_ext);
      end
      if (s3_dist_in == '0) begin
         s3_back_in = '0;
      end else begin
         s3_back_in = DistW'(DistXW'(Span) - DistXW'(s3_dist_in));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_item_ff <= in_item;
         s1_pm_ff   <= s1_pm_in;
         s1_hm_ff   <= s1_hm_in;
      end
      if (s2_adv) begin
         s2_item_ff <= s1_item_ff;
         s2_pm_ff   <= s2_pm_in;
         s2_hm_ff   <= s2_hm_in;
      end
      if (s3_adv) begin
         s3_item_ff <= s2_item_ff;
         s3_dist_ff <= s3_dist_in;
         s3_back_ff <= s3_back_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;
   assign out_dist  = s3_dist_ff;
   assign out_back  = s3_back_ff;

endmodule

[sv/mhcps_eye.sv]
`timescale 1ns / 1ps
// Two pipeline stages: eye hit flags for every tail distance, then the
// farthest hit and its dimming reciprocal. Uses mhcps_pkg.

module mhcps_eye #(
   parameter int Span     = 100,
   parameter int DistW    = 7,
   parameter int TailSpan = 51,
   parameter int DimStep  = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  mhcps_pkg::item_type                  in_item,
   input  logic [DistW-1:0]                     in_dist,
   input  logic [DistW-1:0]                     in_back,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output mhcps_pkg::item_type                  out_item,
   output mhcps_pkg::src_type                   out_src,
   output logic [mhcps_pkg::RECIP_W-1:0]        out_recip
);

   logic                              s4_valid_ff, s5_valid_ff, s4_valid_in, s5_valid_in;
   logic                              s4_adv, s5_adv;
   mhcps_pkg::item_type               s4_item_ff, s5_item_ff;
   logic [TailSpan-1:1]               s4_hit_ff, s4_hit_in;
   logic                              s4_zero_ff;
   mhcps_pkg::src_type                s5_src_ff, s5_src_in;
   logic [mhcps_pkg::RECIP_W-1:0]     s5_recip_ff, s5_recip_in;
   logic [mhcps_pkg::RECIP_W-1:0]     recip_tab [1:TailSpan-1];
   logic                              found;

   assign s5_adv   = ~s5_valid_ff | out_ready;
   assign s4_adv   = ~s4_valid_ff | s5_adv;
   assign in_ready = s4_adv;

   assign s4_valid_in = s4_adv ? in_valid    : s4_valid_ff;
   assign s5_valid_in = s5_adv ? s4_valid_ff : s5_valid_ff;

   // Per tail distance: leading eye matches d, trailing eye matches back within head
   for (genvar g = 1; g < TailSpan; g++) begin : g_dist
      localparam int Jm    = g % Span;
      localparam int Div   = (g + DimStep - 1) / DimStep;
      localparam int Recip = (mhcps_pkg::RECIP_ONE + Div - 1) / Div;
      assign recip_tab[g] = mhcps_pkg::RECIP_W'(Recip);
      assign s4_hit_in[g] = (in_dist == DistW'(Jm)) ||
                            ((int'(in_item.head) >= g) && (in_back == DistW'(Jm)));
   end

   // Largest distance wins
   always_comb begin
      found       = 1'b0;
      s5_recip_in = '0;
      for (int j = 1; j < TailSpan; j++) begin
         if (s4_hit_ff[j]) begin
            found       = 1'b1;
            s5_recip_in = recip_tab[j];
         end
      end
      if (!s4_item_ff.in_range) begin
         s5_src_in = mhcps_pkg::SRC_BLANK;
      end else if (found) begin
         s5_src_in = mhcps_pkg::SRC_DIM;
      end else if (s4_zero_ff) begin
         s5_src_in = mhcps_pkg::SRC_FULL;
      end else begin
         s5_src_in = mhcps_pkg::SRC_KEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_adv) begin
         s4_item_ff <= in_item;
         s4_hit_ff  <= s4_hit_in;
         s4_zero_ff <= (in_dist == '0);
      end
      if (s5_adv) begin
         s5_item_ff  <= s4_item_ff;
         s5_src_ff   <= s5_src_in;
         s5_recip_ff <= s5_recip_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_item  = s5_item_ff;
   assign out_src   = s5_src_ff;
   assign out_recip = s5_recip_ff;

endmodule

[sv/mhcps_dim.sv]
`timescale 1ns / 1ps
// One pipeline stage: each color channel times the reciprocal, upper bits
// kept as the dimmed channel. Uses mhcps_pkg.

module mhcps_dim (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  mhcps_pkg::item_type                  in_item,
   input  mhcps_pkg::src_type                   in_src,
   input  logic [mhcps_pkg::RECIP_W-1:0]        in_recip,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output mhcps_pkg::item_type                  out_item,
   output mhcps_pkg::src_type                   out_src,
   output logic [mhcps_pkg::COLOR_W-1:0]        out_dimmed
);

   localparam int ProdW = mhcps_pkg::RECIP_W + mhcps_pkg::CH_W;
   localparam int Chans = mhcps_pkg::COLOR_W / mhcps_pkg::CH_W;

   logic                              s6_valid_ff, s6_valid_in, s6_adv;
   mhcps_pkg::item_type               s6_item_ff;
   mhcps_pkg::src_type                s6_src_ff;
   logic [mhcps_pkg::COLOR_W-1:0]     s6_dimmed_ff, s6_dimmed_in;

   assign s6_adv      = ~s6_valid_ff | out_ready;
   assign in_ready    = s6_adv;
   assign s6_valid_in = s6_adv ? in_valid : s6_valid_ff;

   // One multiplier per channel
   for (genvar c = 0; c < Chans; c++) begin : g_chan
      logic [ProdW-1:0] prod;
      assign prod = ProdW'(in_item.color[c*mhcps_pkg::CH_W +: mhcps_pkg::CH_W]) *
                    ProdW'(in_recip);
      assign s6_dimmed_in[c*mhcps_pkg::CH_W +: mhcps_pkg::CH_W] =
         prod[mhcps_pkg::RECIP_SHIFT +: mhcps_pkg::CH_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s6_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s6_adv) begin
         s6_item_ff   <= in_item;
         s6_src_ff    <= in_src;
         s6_dimmed_ff <= s6_dimmed_in;
      end
   end

   assign out_valid  = s6_valid_ff;
   assign out_item   = s6_item_ff;
   assign out_src    = s6_src_ff;
   assign out_dimmed = s6_dimmed_ff;

endmodule

[bench/comet_shade_checker.sv]
`timescale 1ns / 1ps
// Shade checker for the comet pixel shader: watches both channels, predicts each
// pixel color and compares the returned beats in order. Depends on mhcps_pkg.

module comet_shade_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [mhcps_pkg::PIX_W-1:0]   req_pixel_index,
   input  logic [mhcps_pkg::PIX_W-1:0]   req_head_position,
   input  logic [mhcps_pkg::COLOR_W-1:0] req_drop_color,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [mhcps_pkg::PIX_W-1:0]   rsp_out_index,
   input  logic [mhcps_pkg::COLOR_W-1:0] rsp_out_color,
   output int                            mismatches,
   output int                            shades_pending
);

   typedef struct packed {
      logic [mhcps_pkg::PIX_W-1:0]   index;
      logic [mhcps_pkg::COLOR_W-1:0] color;
   } shade_beat_type;

   // Mirror of the frame store and the colors still owed by the block
   logic [mhcps_pkg::COLOR_W-1:0] pixel_colors [mhcps_pkg::STRIP_PIXELS];
   shade_beat_type                owed_shades [$];

   // New color of one pixel; the caller writes it back for in-range pixels
   function automatic logic [mhcps_pkg::COLOR_W-1:0] shade_pixel(
         input logic [mhcps_pkg::PIX_W-1:0]   pix,
         input logic [mhcps_pkg::PIX_W-1:0]   head,
         input logic [mhcps_pkg::COLOR_W-1:0] color);
      int span, pi, hi, d, back, j, dv;
      logic [mhcps_pkg::COLOR_W-1:0] result;
      bit hit;
      span = mhcps_pkg::STRIP_PIXELS / mhcps_pkg::HEADS;
      if (span == 0) span = 1;
      pi = pix;
      hi = head;
      d = ((pi % span) + span - (hi % span)) % span;
      back = (span - d) % span;
      result = '0;
      hit = 1'b0;
      if (pi < mhcps_pkg::STRIP_PIXELS) begin
         // farthest eye distance wins, leading or trailing
         for (j = mhcps_pkg::TAIL_SPAN - 1; j >= 1 && !hit; j--) begin
            if ((j % span) == d || (j <= hi && (j % span) == back)) begin
               dv = (j + mhcps_pkg::DIM_STEP - 1) / mhcps_pkg::DIM_STEP;
               if (dv == 0) dv = 1;
               result[23:16] = mhcps_pkg::CH_W'(int'(color[23:16]) / dv);
               result[15:8]  = mhcps_pkg::CH_W'(int'(color[15:8]) / dv);
               result[7:0]   = mhcps_pkg::CH_W'(int'(color[7:0]) / dv);
               hit = 1'b1;
            end
         end
         if (!hit) result = (d == 0) ? color : pixel_colors[pi];
      end
      return result;
   endfunction

   always @(posedge clock) begin
      shade_beat_type want, fresh;
      if (reset) begin
         owed_shades.delete();
         for (int i = 0; i < mhcps_pkg::STRIP_PIXELS; i++) pixel_colors[i] = '0;
         mismatches = 0;
      end else begin
         // returned beat against the oldest owed color
         if (rsp_valid && rsp_ready) begin
            if (owed_shades.size() == 0) begin
               $display("%0t: unexpected beat, expected none, got index %0d color %06h",
                        $time, rsp_out_index, rsp_out_color);
               mismatches++;
            end else begin
               want = owed_shades.pop_front();
               if (rsp_out_index !== want.index) begin
                  $display("%0t: out_index expected %0d, got %0d",
                           $time, want.index, rsp_out_index);
                  mismatches++;
               end
               if (rsp_out_color !== want.color) begin
                  $display("%0t: out_color of pixel %0d expected %06h, got %06h",
                           $time, want.index, want.color, rsp_out_color);
                  mismatches++;
               end
            end
         end
         // accepted pixel: predict and update the mirror store
         if (req_valid && req_ready) begin
            fresh.index = req_pixel_index;
            fresh.color = shade_pixel(req_pixel_index, req_head_position, req_drop_color);
            if (int'(req_pixel_index) < mhcps_pkg::STRIP_PIXELS)
               pixel_colors[req_pixel_index] = fresh.color;
            owed_shades.push_back(fresh);
         end
      end
      shades_pending <= owed_shades.size();
   end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the comet pixel shader: clock, reset, pixel stimulus and
// output stalls. Depends on mhcps_pkg, the shader core and comet_shade_checker.

module tb_top;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [mhcps_pkg::PIX_W-1:0]   req_pixel_index;
   logic [mhcps_pkg::PIX_W-1:0]   req_head_position;
   logic [mhcps_pkg::COLOR_W-1:0] req_drop_color;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [mhcps_pkg::PIX_W-1:0]   rsp_out_index;
   logic [mhcps_pkg::COLOR_W-1:0] rsp_out_color;
   int                            mismatches;
   int                            shades_pending;
   int                            sent_beats;

   multi_head_comet_pixel_shader_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel_index   (req_pixel_index),
      .req_head_position (req_head_position),
      .req_drop_color    (req_drop_color),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_index     (rsp_out_index),
      .rsp_out_color     (rsp_out_color)
   );

   comet_shade_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel_index   (req_pixel_index),
      .req_head_position (req_head_position),
      .req_drop_color    (req_drop_color),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_index     (rsp_out_index),
      .rsp_out_color     (rsp_out_color),
      .mismatches        (mismatches),
      .shades_pending    (shades_pending)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Idle length: mostly none, some short, a few long
   function automatic int idle_cycles();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // One pixel beat, held until accepted; returns just after the accepting edge
   task automatic send_pixel(input logic [mhcps_pkg::PIX_W-1:0] pix,
                             input logic [mhcps_pkg::PIX_W-1:0] head,
                             input logic [mhcps_pkg::COLOR_W-1:0] color, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_pixel_index   <= pix;
      req_head_position <= head;
      req_drop_color    <= color;
      do @(posedge clock); while (!req_ready);
      sent_beats++;
   endtask

   // Hold the sender off until every owed color has come back
   task automatic drain_shades();
      req_valid <= 1'b0;
      do @(posedge clock); while (shades_pending != 0);
   endtask

   // Output stalls, with long stall-free stretches now and then
   initial begin
      int hold;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         hold = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                            : $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (hold) @(posedge clock);
         hold = idle_cycles();
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      int mode, count, base, burst, target;
      logic [mhcps_pkg::PIX_W-1:0]   head, pix;
      logic [mhcps_pkg::COLOR_W-1:0] color;
      sent_beats = 0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_pixel_index   <= '0;
      req_head_position <= '0;
      req_drop_color    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: heads, both eyes, eye edges, kept pixels, out of range
      send_pixel(9'd0,   9'd0,   24'hFFFFFF, 0);   // at the head
      send_pixel(9'd1,   9'd0,   24'hFFFFFF, 0);   // nearest leading eye pixel
      send_pixel(9'd50,  9'd0,   24'hFF0000, 0);   // far end of leading eye
      send_pixel(9'd51,  9'd0,   24'h00FF00, 0);   // just past eye, keeps zero
      send_pixel(9'd99,  9'd10,  24'h0000FF, 0);   // trailing eye beyond head limit
      send_pixel(9'd100, 9'd11,  24'h0000FF, 0);   // trailing eye at head limit
      send_pixel(9'd0,   9'd511, 24'hFFFFFF, 0);   // head past the strip
      send_pixel(9'd511, 9'd0,   24'hFFFFFF, 0);   // pixel past the strip
      send_pixel(9'd300, 9'd511, 24'h123456, 0);   // first pixel past the strip
      send_pixel(9'd299, 9'd299, 24'hABCDEF, 0);   // last pixel at its head
      send_pixel(9'd200, 9'd100, 24'h808080, 0);   // third head
      send_pixel(9'd60,  9'd10,  24'hC0FFEE, 0);   // leading eye, then kept, then trailing eye
      send_pixel(9'd60,  9'd0,   24'h000000, 0);
      send_pixel(9'd60,  9'd299, 24'h000000, 0);
      send_pixel(9'd149, 9'd199, 24'hFFFFFF, 0);   // leading and trailing eye hit at once
      send_pixel(9'd8,   9'd0,   24'h070707, 1);   // last pixel dimmed by one
      send_pixel(9'd9,   9'd0,   24'hFFFFFF, 2);   // first pixel dimmed by two
      send_pixel(9'd255, 9'd256, 24'h000000, 0);   // trailing eye, black
      send_pixel(9'd256, 9'd256, 24'hFFFFFF, 0);
      drain_shades();

      // random: comet sweeps, repeated pixels and raw noise
      target = sent_beats + 1550;
      while (sent_beats < target) begin
         if (sent_beats > target - 800 && sent_beats < target - 770) drain_shades();
         mode = $urandom_range(0, 9);
         burst = ($urandom_range(0, 3) == 0);
         if (mode <= 5) begin
            head  = ($urandom_range(0, 9) == 0) ?
                    mhcps_pkg::PIX_W'($urandom_range(300, 511)) :
                    mhcps_pkg::PIX_W'($urandom_range(0, 299));
            color = mhcps_pkg::COLOR_W'($urandom);
            base  = $urandom_range(0, mhcps_pkg::STRIP_PIXELS - 1);
            count = $urandom_range(8, 40);
            for (int k = 0; k < count; k++) begin
               pix = mhcps_pkg::PIX_W'((base + k) % mhcps_pkg::STRIP_PIXELS);
               send_pixel(pix, head, color, burst ? 0 : idle_cycles());
            end
         end else if (mode == 6) begin
            pix = mhcps_pkg::PIX_W'($urandom_range(0, mhcps_pkg::STRIP_PIXELS - 1));
            count = $urandom_range(2, 6);
            for (int k = 0; k < count; k++)
               send_pixel(pix, mhcps_pkg::PIX_W'($urandom_range(0, 511)),
                          mhcps_pkg::COLOR_W'($urandom), 0);
         end else begin
            count = $urandom_range(5, 15);
            for (int k = 0; k < count; k++)
               send_pixel(mhcps_pkg::PIX_W'($urandom_range(0, 511)),
                          mhcps_pkg::PIX_W'($urandom_range(0, 511)),
                          mhcps_pkg::COLOR_W'($urandom), burst ? 0 : idle_cycles());
         end
      end

      drain_shades();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && shades_pending == 0) begin
         $display("** multi_head_comet_pixel_shader_core: PASSED **");
      end else begin
         $display("** multi_head_comet_pixel_shader_core: FAILED **");
      end
      $finish;
   end

   // Run limit
   initial begin
      #20000000;
      $display("** multi_head_comet_pixel_shader_core: FAILED **");
      $finish;
   end

endmodule
